// File: design/ffs_pkg.sv
// ----------------------------------------------------------------------------
// ffs_pkg
// Shared types and constants for the framed field splitter.
// ----------------------------------------------------------------------------
package ffs_pkg;

    localparam int unsigned INPUT_LIMIT     = 99;
    localparam int unsigned MAX_TOKENS      = 10;
    localparam int unsigned MAX_TOKEN_CHARS = 49;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned SEEN_W  = 7;
    localparam int unsigned TOKEN_W = 4;
    localparam int unsigned POS_W   = 6;

    localparam logic [CHAR_W-1:0] CH_OPEN  = 8'h3C;  // '<'
    localparam logic [CHAR_W-1:0] CH_CLOSE = 8'h3E;  // '>'
    localparam logic [CHAR_W-1:0] CH_PIPE  = 8'h7C;  // '|'
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;

    localparam logic KIND_CHAR  = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef enum logic [3:0] {
        PH_SKIP_OPEN  = 4'b0001,
        PH_SKIP_CLOSE = 4'b0010,
        PH_BODY       = 4'b0100,
        PH_DONE       = 4'b1000
    } phase_t;

    typedef struct packed {
        logic               kind;
        logic [CHAR_W-1:0]  token_char;
        logic [TOKEN_W-1:0] token_index;
        logic [POS_W-1:0]   char_pos;
        logic               token_first;
        logic [TOKEN_W-1:0] token_count;
        logic               frame_last;
    } result_t;

endpackage

// File: design/framed_field_splitter.sv
// ----------------------------------------------------------------------------
// framed_field_splitter
// Streaming frame tokenizer with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   s_ch / s_end_mark carry one message character per request; a request
//   with s_end_mark high closes the message. Leading '<' then '>' are
//   skipped, the body ends at the next '<' or '>', and is split on '|'.
//   Every kept character gives one m_ request (m_kind = 0) with its token
//   index and position; the end request gives the token count (m_kind = 1,
//   m_frame_last = 1). Ignored characters give no request.
//   Results are registered in the result register, or first in the skid
//   entry when m_ready is low. Throughput: one request per cycle while
//   s_ready is high; the per-character state update is combinational logic
//   between the state registers and the result register.
//   Reset (aresetn low, synchronous) clears the framing state and empties
//   the result register and skid entry.
//   When m_ready is held low, one more result is parked in the skid entry,
//   then s_ready drops until the receiver takes results again.
// ----------------------------------------------------------------------------
module framed_field_splitter
    import ffs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CHAR_W-1:0]  s_ch,
    input  logic               s_end_mark,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_kind,
    output logic [CHAR_W-1:0]  m_token_char,
    output logic [TOKEN_W-1:0] m_token_index,
    output logic [POS_W-1:0]   m_char_pos,
    output logic               m_token_first,
    output logic [TOKEN_W-1:0] m_token_count,
    output logic               m_frame_last
);

    logic    in_fire;
    logic    res_valid;
    result_t res;
    result_t out_data;

    assign in_fire = s_valid && s_ready;

    ffs_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .ch        (s_ch),
        .end_mark  (s_end_mark),
        .res_valid (res_valid),
        .res       (res)
    );

    ffs_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (res_valid),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (out_data),
        .out_ready (m_ready)
    );

    assign m_kind        = out_data.kind;
    assign m_token_char  = out_data.token_char;
    assign m_token_index = out_data.token_index;
    assign m_char_pos    = out_data.char_pos;
    assign m_token_first = out_data.token_first;
    assign m_token_count = out_data.token_count;
    assign m_frame_last  = out_data.frame_last;

    a_skid_implies_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid entry held while result register empty");

    a_count_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_kind == KIND_COUNT) == m_frame_last)
        else $error("frame_last does not match result kind");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_COUNT |-> m_token_count <= TOKEN_W'(MAX_TOKENS))
        else $error("token count exceeds limit");

    a_end_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_end_mark |=> m_valid)
        else $error("end request produced no result");

endmodule

// File: design/ffs_core.sv
// ----------------------------------------------------------------------------
// ffs_core
// Per-character framing and tokenizing state; builds at most one result
// for every accepted request.
// ----------------------------------------------------------------------------
module ffs_core
    import ffs_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_fire,
    input  logic [CHAR_W-1:0] ch,
    input  logic              end_mark,
    output logic              res_valid,
    output result_t           res
);

    localparam logic [SEEN_W-1:0]  LIMIT_V  = SEEN_W'(INPUT_LIMIT);
    localparam logic [TOKEN_W-1:0] MAXTOK_V = TOKEN_W'(MAX_TOKENS);
    localparam logic [POS_W-1:0]   MAXCH_V  = POS_W'(MAX_TOKEN_CHARS);

    phase_t             phase_reg, phase_next;
    logic [SEEN_W-1:0]  seen_reg, seen_next;
    logic [TOKEN_W-1:0] tokens_reg, tokens_next;
    logic [POS_W-1:0]   len_reg, len_next;
    logic               inside_reg, inside_next;

    logic               to_body;
    logic [TOKEN_W-1:0] tok_new;
    logic [POS_W-1:0]   cur_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SKIP_OPEN;
            seen_reg   <= '0;
            tokens_reg <= '0;
            len_reg    <= '0;
            inside_reg <= 1'b0;
        end else if (in_fire) begin
            phase_reg  <= phase_next;
            seen_reg   <= seen_next;
            tokens_reg <= tokens_next;
            len_reg    <= len_next;
            inside_reg <= inside_next;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        seen_next   = seen_reg;
        tokens_next = tokens_reg;
        len_next    = len_reg;
        inside_next = inside_reg;
        to_body     = 1'b0;
        tok_new     = tokens_reg;
        cur_len     = len_reg;
        res_valid   = 1'b0;
        res         = '0;

        if (end_mark) begin
            res_valid         = in_fire;
            res.kind          = KIND_COUNT;
            res.token_count   = tokens_reg;
            res.frame_last    = 1'b1;
            phase_next        = PH_SKIP_OPEN;
            seen_next         = '0;
            tokens_next       = '0;
            len_next          = '0;
            inside_next       = 1'b0;
        end else if (seen_reg < LIMIT_V) begin
            seen_next = seen_reg + SEEN_W'(1);
            if (ch == CH_NUL) begin
                phase_next = PH_DONE;
            end else begin
                case (phase_reg)
                    PH_SKIP_OPEN: begin
                        if (ch == CH_CLOSE) begin
                            phase_next = PH_SKIP_CLOSE;
                        end else if (ch != CH_OPEN) begin
                            phase_next = PH_BODY;
                            to_body    = 1'b1;
                        end
                    end
                    PH_SKIP_CLOSE: begin
                        if (ch == CH_OPEN) begin
                            phase_next = PH_DONE;
                        end else if (ch != CH_CLOSE) begin
                            phase_next = PH_BODY;
                            to_body    = 1'b1;
                        end
                    end
                    PH_BODY: begin
                        if (ch == CH_OPEN || ch == CH_CLOSE) begin
                            phase_next = PH_DONE;
                        end else begin
                            to_body = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        if (to_body) begin
            if (ch == CH_PIPE) begin
                inside_next = 1'b0;
            end else if (inside_reg || tokens_reg < MAXTOK_V) begin
                if (!inside_reg) begin
                    tok_new     = tokens_reg + TOKEN_W'(1);
                    tokens_next = tok_new;
                    cur_len     = '0;
                    inside_next = 1'b1;
                    len_next    = '0;
                end
                if (cur_len < MAXCH_V) begin
                    len_next        = cur_len + POS_W'(1);
                    res_valid       = in_fire;
                    res.kind        = KIND_CHAR;
                    res.token_char  = ch;
                    res.token_index = tok_new - TOKEN_W'(1);
                    res.char_pos    = cur_len;
                    res.token_first = !inside_reg;
                end
            end
        end
    end

endmodule

// File: design/ffs_out_stage.sv
// ----------------------------------------------------------------------------
// ffs_out_stage
// Result register with one skid entry; input ready is a register output.
// ----------------------------------------------------------------------------
module ffs_out_stage
    import ffs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  result_t in_data,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_data,
    input  logic    out_ready
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_valid;
                main_next       = in_data;
            end
        end else if (in_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: verif/framed_field_splitter_test.sv
// ----------------------------------------------------------------------------
// framed_field_splitter_test
// Drives character streams into the frame tokenizer with random gaps on both
// channels. The scoreboard keeps its own copy of the framing and token state,
// predicts every character and count request, and checks them in order.
// ----------------------------------------------------------------------------
module framed_field_splitter_test
    import ffs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned ITEMS_PER_PASS = 230;

    class split_scoreboard;
        phase_t             phase;
        logic [SEEN_W-1:0]  chars_seen;
        logic [TOKEN_W-1:0] tokens_found;
        logic [POS_W-1:0]   token_length;
        logic               inside_token;
        result_t            expected_q[$];
        int unsigned        errors;

        function new();
            clear();
            errors = 0;
        endfunction

        function void clear();
            phase        = PH_SKIP_OPEN;
            chars_seen   = '0;
            tokens_found = '0;
            token_length = '0;
            inside_token = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void take_body_char(logic [CHAR_W-1:0] c);
            result_t r;
            logic    first;
            first = 1'b0;
            if (c == CH_PIPE) begin
                inside_token = 1'b0;
                return;
            end
            if (!inside_token) begin
                if (tokens_found >= MAX_TOKENS) return;
                tokens_found = tokens_found + 1'b1;
                token_length = '0;
                inside_token = 1'b1;
                first        = 1'b1;
            end
            if (token_length >= MAX_TOKEN_CHARS) return;
            r.kind        = KIND_CHAR;
            r.token_char  = c;
            r.token_index = tokens_found - 1'b1;
            r.char_pos    = token_length;
            r.token_first = first;
            r.token_count = '0;
            r.frame_last  = 1'b0;
            expected_q.push_back(r);
            token_length = token_length + 1'b1;
        endfunction

        function void note_request(logic [CHAR_W-1:0] c, logic end_mark);
            result_t r;
            if (end_mark) begin
                r.kind        = KIND_COUNT;
                r.token_char  = '0;
                r.token_index = '0;
                r.char_pos    = '0;
                r.token_first = 1'b0;
                r.token_count = tokens_found;
                r.frame_last  = 1'b1;
                expected_q.push_back(r);
                clear();
                return;
            end
            if (chars_seen >= INPUT_LIMIT) return;
            chars_seen = chars_seen + 1'b1;
            if (c == CH_NUL) begin
                phase = PH_DONE;
                return;
            end
            case (phase)
                PH_SKIP_OPEN: begin
                    if (c == CH_OPEN) return;
                    if (c == CH_CLOSE) begin
                        phase = PH_SKIP_CLOSE;
                        return;
                    end
                    phase = PH_BODY;
                    take_body_char(c);
                end
                PH_SKIP_CLOSE: begin
                    if (c == CH_CLOSE) return;
                    if (c == CH_OPEN) begin
                        phase = PH_DONE;
                        return;
                    end
                    phase = PH_BODY;
                    take_body_char(c);
                end
                PH_BODY: begin
                    if (c == CH_OPEN || c == CH_CLOSE) begin
                        phase = PH_DONE;
                        return;
                    end
                    take_body_char(c);
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                $error("unexpected result: kind %0d char %0d", got.kind, got.token_char);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("kind", want.kind, got.kind);
            check_field("token_char", want.token_char, got.token_char);
            check_field("token_index", want.token_index, got.token_index);
            check_field("char_pos", want.char_pos, got.char_pos);
            check_field("token_first", want.token_first, got.token_first);
            check_field("token_count", want.token_count, got.token_count);
            check_field("frame_last", want.frame_last, got.frame_last);
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_ch = '0;
    logic               s_end_mark = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_kind;
    logic [CHAR_W-1:0]  m_token_char;
    logic [TOKEN_W-1:0] m_token_index;
    logic [POS_W-1:0]   m_char_pos;
    logic               m_token_first;
    logic [TOKEN_W-1:0] m_token_count;
    logic               m_frame_last;

    split_scoreboard board = new();
    int unsigned     send_idle_pct = 27;
    int unsigned     recv_idle_pct = 78;
    int unsigned     chars_sent = 0;
    int unsigned     quiet_cycles = 0;

    framed_field_splitter dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .s_end_mark    (s_end_mark),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_token_char  (m_token_char),
        .m_token_index (m_token_index),
        .m_char_pos    (m_char_pos),
        .m_token_first (m_token_first),
        .m_token_count (m_token_count),
        .m_frame_last  (m_frame_last)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result('{kind: m_kind, token_char: m_token_char,
                                 token_index: m_token_index, char_pos: m_char_pos,
                                 token_first: m_token_first, token_count: m_token_count,
                                 frame_last: m_frame_last});
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [CHAR_W-1:0] c, input logic end_mark);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid    <= 1'b1;
        s_ch       <= c;
        s_end_mark <= end_mark;
        do @(posedge aclk); while (!s_ready);
        board.note_request(c, end_mark);
        chars_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] body_byte();
        logic [CHAR_W-1:0] c;
        do c = CHAR_W'($urandom_range(1, 255));
        while (c == CH_OPEN || c == CH_CLOSE || c == CH_PIPE);
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] noise_byte();
        case ($urandom_range(7))
            0: return CH_NUL;
            1: return CH_OPEN;
            2: return CH_CLOSE;
            3: return CH_PIPE;
            default: return CHAR_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_frame();
        logic [CHAR_W-1:0] msg[$];
        int unsigned       roll;
        int unsigned       n_tok;
        int unsigned       len;
        roll = $urandom_range(99);
        if (roll < 85) begin
            repeat ($urandom_range(2)) msg.push_back(CH_OPEN);
            repeat ($urandom_range(2)) msg.push_back(CH_CLOSE);
            if (roll < 5) n_tok = $urandom_range(11, 14);
            else if (roll < 9) n_tok = $urandom_range(1, 3);
            else n_tok = $urandom_range(0, 5);
            for (int t = 0; t < n_tok; t++) begin
                if (t > 0 || $urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, 2)) msg.push_back(CH_PIPE);
                end
                if (roll >= 5 && roll < 9) len = $urandom_range(44, 56);
                else len = $urandom_range(1, 6);
                repeat (len) msg.push_back(body_byte());
            end
            case ($urandom_range(5))
                0: msg.push_back(CH_PIPE);
                1: begin
                    msg.push_back($urandom_range(1) ? CH_OPEN : CH_CLOSE);
                    repeat ($urandom_range(3)) msg.push_back(noise_byte());
                end
                2: begin
                    msg.push_back(CH_NUL);
                    repeat ($urandom_range(3)) msg.push_back(noise_byte());
                end
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(12)) msg.push_back(noise_byte());
        end
        foreach (msg[i]) send_request(msg[i], 1'b0);
        send_request(CHAR_W'($urandom_range(255)), 1'b1);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty message
        send_request(8'h00, 1'b1);
        // skipped marks, empty field, extreme characters
        send_request(CH_OPEN, 1'b0);
        send_request(CH_OPEN, 1'b0);
        send_request(CH_CLOSE, 1'b0);
        send_request(CH_CLOSE, 1'b0);
        send_request(8'hFF, 1'b0);
        send_request(CH_PIPE, 1'b0);
        send_request(CH_PIPE, 1'b0);
        send_request(8'h01, 1'b0);
        send_request("c", 1'b0);
        send_request(8'hFF, 1'b1);
        // open mark while skipping close marks
        send_request(CH_CLOSE, 1'b0);
        send_request(CH_OPEN, 1'b0);
        send_request("x", 1'b0);
        send_request(8'h5A, 1'b1);
        // zero character stops the string
        send_request("a", 1'b0);
        send_request(CH_NUL, 1'b0);
        send_request("b", 1'b0);
        send_request(8'hA5, 1'b1);
        // character after the body
        send_request("q", 1'b0);
        send_request(CH_CLOSE, 1'b0);
        send_request("r", 1'b0);
        send_request(8'h00, 1'b1);

        for (int pass = 0; pass < 3; pass++) begin
            case (pass)
                0: begin
                    send_idle_pct = 27;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 27;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (chars_sent < (pass + 1) * ITEMS_PER_PASS) send_frame();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/ffs_pkg.sv
design/ffs_core.sv
design/ffs_out_stage.sv
design/framed_field_splitter.sv
verif/framed_field_splitter_test.sv
